@@ hw/rtl/usd_pkg.sv @@
// shared types, constants and decode functions for the utf-8 sanitizing decoder
package usd_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned CapWidth      = 16;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned CpWidth       = 21;
  localparam int unsigned LenWidth      = 3;

  localparam logic [CapWidth-1:0] CapReset = 16'd512;

  // byte classes
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Lo    = 8'hC2;
  localparam logic [7:0] Lead2Hi    = 8'hDF;
  localparam logic [7:0] Lead3Lo    = 8'hE0;
  localparam logic [7:0] Lead3Hi    = 8'hEF;
  localparam logic [7:0] Lead4Lo    = 8'hF0;
  localparam logic [7:0] Lead4Hi    = 8'hF4;

  // payload masks of lead and continuation bytes
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] ContBits  = 8'h3F;

  // one finished character or one end marker, burst out by the back end
  typedef struct packed {
    logic [3:0][ByteWidth-1:0] seq;
    logic [LenWidth-1:0]       len;
    logic [CpWidth-1:0]        cp;
    logic                      is_end;
  } job_t;

  // length of a character from its lead byte, 0 for a stray or invalid lead
  function automatic logic [LenWidth-1:0] lead_len(input logic [7:0] b);
    logic [LenWidth-1:0] len;
    len = 3'd0;
    if (b < AsciiLimit) begin
      len = 3'd1;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      len = 3'd2;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      len = 3'd3;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [CpWidth-1:0] decode_cp(input logic [3:0][7:0] seq,
                                                   input logic [LenWidth-1:0] len);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [CpWidth-1:0] cp;
    b0 = seq[0];
    b1 = seq[1] & ContBits;
    b2 = seq[2] & ContBits;
    b3 = seq[3] & ContBits;
    case (len)
      3'd1: cp = {13'd0, b0};
      3'd2: cp = {10'd0, b0[4:0] & Lead2Mask[4:0], b1[5:0]};
      3'd3: cp = {5'd0, b0[3:0] & Lead3Mask[3:0], b1[5:0], b2[5:0]};
      3'd4: cp = {b0[2:0] & Lead4Mask[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = '0;
    endcase
    return cp;
  endfunction

endpackage

@@ hw/rtl/usd_front.sv @@
// front end: byte classification, character assembly and capacity check
module usd_front #(
  parameter int unsigned COUNT_WIDTH = usd_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          string_done_i,
  input  logic [usd_pkg::CapWidth-1:0]  capacity_i,
  input  logic                          q_full_i,
  output logic                          full_o,
  output logic                          q_push_o,
  output usd_pkg::job_t                 q_data_o
);

  localparam int unsigned SumW =
    ((COUNT_WIDTH > usd_pkg::CapWidth) ? COUNT_WIDTH : usd_pkg::CapWidth) + 1;

  logic [2:0][7:0]         held_q, held_d;
  logic [1:0]              hc_q, hc_d;
  logic [2:0]              exp_q, exp_d;
  logic [COUNT_WIDTH-1:0]  written_q, written_d;
  logic                    stopped_q, stopped_d;

  logic                    accept;
  logic                    is_cont;
  logic [2:0]              lead;
  logic                    emit;
  logic [2:0]              len;
  logic [3:0][7:0]         seq;
  logic [SumW-1:0]         sum;
  logic                    fits;

  assign full_o  = q_full_i;
  assign accept  = push_i & ~q_full_i;
  assign is_cont = (in_byte_i & usd_pkg::ContMask) == usd_pkg::ContTag;
  assign lead    = usd_pkg::lead_len(in_byte_i);

  // room for the character plus the terminator, and no counter overflow
  assign sum  = SumW'(written_q) + SumW'(len);
  assign fits = (sum[SumW-1:COUNT_WIDTH] == '0) && (sum < SumW'(capacity_i));

  always_comb begin
    held_d    = held_q;
    hc_d      = hc_q;
    exp_d     = exp_q;
    written_d = written_q;
    stopped_d = stopped_q;
    emit      = 1'b0;
    len       = 3'd0;
    seq       = '0;
    q_push_o  = 1'b0;
    q_data_o  = '0;
    if (accept) begin
      if (string_done_i) begin
        hc_d      = 2'd0;
        exp_d     = 3'd0;
        written_d = '0;
        stopped_d = 1'b0;
        if (capacity_i != '0) begin
          q_push_o        = 1'b1;
          q_data_o.len    = 3'd1;
          q_data_o.is_end = 1'b1;
        end
      end else if (!stopped_q) begin
        if (hc_q != 2'd0 && is_cont) begin
          if (({1'b0, hc_q} + 3'd1) >= exp_q) begin
            emit   = 1'b1;
            len    = {1'b0, hc_q} + 3'd1;
            seq[0] = held_q[0];
            seq[1] = (hc_q > 2'd1) ? held_q[1] : in_byte_i;
            seq[2] = (hc_q > 2'd2) ? held_q[2] : in_byte_i;
            seq[3] = in_byte_i;
            hc_d   = 2'd0;
            exp_d  = 3'd0;
          end else begin
            case (hc_q)
              2'd1:    held_d[1] = in_byte_i;
              2'd2:    held_d[2] = in_byte_i;
              default: held_d[0] = in_byte_i;
            endcase
            hc_d = hc_q + 2'd1;
          end
        end else begin
          // any held partial is dropped and this byte is a new lead
          hc_d  = 2'd0;
          exp_d = 3'd0;
          if (lead == 3'd1) begin
            emit   = 1'b1;
            len    = 3'd1;
            seq[0] = in_byte_i;
          end else if (lead != 3'd0) begin
            held_d[0] = in_byte_i;
            hc_d      = 2'd1;
            exp_d     = lead;
          end
        end
      end
      if (emit) begin
        if (fits) begin
          q_push_o        = 1'b1;
          q_data_o.seq    = seq;
          q_data_o.len    = len;
          q_data_o.cp     = usd_pkg::decode_cp(seq, len);
          written_d       = sum[COUNT_WIDTH-1:0];
        end else begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q      <= 2'd0;
      exp_q     <= 3'd0;
      written_q <= '0;
      stopped_q <= 1'b0;
    end else begin
      hc_q      <= hc_d;
      exp_q     <= exp_d;
      written_q <= written_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

@@ hw/rtl/usd_queue.sv @@
// small job queue between front end and back end
module usd_queue #(
  parameter int unsigned DEPTH = usd_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  usd_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output usd_pkg::job_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  usd_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= next_ptr(wr_q);
      if (do_pop)  rd_q <= next_ptr(rd_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

@@ hw/rtl/usd_back.sv @@
// back end: bursts each queued job into an output register, one result per cycle while results are popped
module usd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  usd_pkg::job_t                 q_head_i,
  output logic                          q_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [7:0]                    out_byte_o,
  output logic                          char_final_o,
  output logic [usd_pkg::CpWidth-1:0]   code_point_o,
  output logic                          end_marker_o,
  output logic                          run_last_o
);

  logic                        vld_q;
  logic [1:0]                  idx_q;
  logic [7:0]                  byte_q;
  logic                        fin_q;
  logic [usd_pkg::CpWidth-1:0] cp_q;
  logic                        endm_q;
  logic                        last_q;

  logic load;
  logic last;

  assign load    = ~vld_q | pop_i;
  assign last    = ({1'b0, idx_q} + 3'd1) == q_head_i.len;
  assign q_pop_o = load & ~q_empty_i & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load) begin
      vld_q <= ~q_empty_i;
      if (!q_empty_i) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      byte_q <= q_head_i.seq[idx_q];
      fin_q  <= last & ~q_head_i.is_end;
      cp_q   <= (last && !q_head_i.is_end) ? q_head_i.cp : '0;
      endm_q <= q_head_i.is_end;
      last_q <= last;
    end
  end

  assign empty_o      = ~vld_q;
  assign out_byte_o   = byte_q;
  assign char_final_o = fin_q;
  assign code_point_o = cp_q;
  assign end_marker_o = endm_q;
  assign run_last_o   = last_q;

endmodule

@@ hw/rtl/utf8_sanitize_decode.sv @@
// top level of the streaming utf-8 sanitizing decoder
//
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// input     | push / full                    | in_byte_i, string_done_i
// results   | empty / pop                    | out_byte_o, char_final_o, code_point_o,
//           |                                | end_marker_o, run_last_o
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata (capacity_bytes at 0)
//
// one byte is taken per cycle while full is low; the front end settles each byte in the cycle it is taken
// a finished character leaves as one result per cycle while results are popped, one result
// per byte, matched by the input bytes that built it
// full rises only when the job queue (QUEUE_DEPTH jobs) is full; the output register lets
// the next result load in the same cycle the current one is popped
// reset is asynchronous, active low, and clears all string state; capacity resets to 512
module utf8_sanitize_decode #(
  parameter int unsigned COUNT_WIDTH = usd_pkg::CountWidthDef,
  parameter int unsigned QUEUE_DEPTH = usd_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          string_done_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte_o,
  output logic                          char_final_o,
  output logic [usd_pkg::CpWidth-1:0]   code_point_o,
  output logic                          end_marker_o,
  output logic                          run_last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic RegCapacity = 1'b0;

  logic [usd_pkg::CapWidth-1:0] cap_q;
  logic                         cfg_wr;

  // job queue link
  logic          q_push, q_pop, q_full, q_empty;
  usd_pkg::job_t q_wdata, q_head;

  // config transaction: register index is the word address
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= usd_pkg::CapReset;
    end else if (cfg_wr && paddr[2] == RegCapacity) begin
      cap_q <= pwdata[usd_pkg::CapWidth-1:0];
    end
  end

  assign prdata = (paddr[2] == RegCapacity) ? {16'd0, cap_q} : 32'd0;

  // front end: classify bytes, assemble characters, check capacity
  usd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .in_byte_i     (in_byte_i),
    .string_done_i (string_done_i),
    .capacity_i    (cap_q),
    .q_full_i      (q_full),
    .full_o        (full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  // decoupling queue of whole characters and end markers
  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // back end: one result transaction per cycle while results are popped
  usd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .char_final_o (char_final_o),
    .code_point_o (code_point_o),
    .end_marker_o (end_marker_o),
    .run_last_o   (run_last_o)
  );

endmodule
